/* rtl/iirb_pkg.sv */
package iirb_pkg;

    localparam int SmpW      = 16;
    localparam int CoefW     = 18;
    localparam int FracW     = 16;
    localparam int HistDepth = 3;
    localparam int MaxOrder  = 4;
    localparam int DefOrder  = 4;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = CoefW;
    localparam int ProdW     = CoefW + SmpW;
    // seven products plus headroom
    localparam int AccW      = ProdW + 4;

    localparam logic signed [CoefW-1:0] FwdCoef0Rst = CoefW'(2**FracW);
    localparam logic signed [AccW-1:0]  SmpMax      = AccW'(2**(SmpW-1) - 1);
    localparam logic signed [AccW-1:0]  SmpMin      = -AccW'(2**(SmpW-1));

    typedef enum logic [CfgIdxW-1:0] {
        REG_BIAS  = 3'd0,
        REG_FEED1 = 3'd1,
        REG_FEED2 = 3'd2,
        REG_FEED3 = 3'd3,
        REG_FWD0  = 3'd4,
        REG_FWD1  = 3'd5,
        REG_FWD2  = 3'd6,
        REG_FWD3  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [SmpW-1:0]         bias;
        logic [HistDepth:1][CoefW-1:0]  feed;
        logic [MaxOrder-1:0][CoefW-1:0] fwd;
    } t_cfg;

    typedef logic [HistDepth-1:0][SmpW-1:0] t_hist;

    function automatic logic signed [SmpW-1:0] sat_smp(input logic signed [AccW-1:0] v);
        logic signed [SmpW-1:0] r;
        if (v > SmpMax) begin
            r = SmpMax[SmpW-1:0];
        end else if (v < SmpMin) begin
            r = SmpMin[SmpW-1:0];
        end else begin
            r = v[SmpW-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/iirb_in_if.sv */
interface iirb_in_if import iirb_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [SmpW-1:0] sample_in;

    modport source(output valid, output sample_in, input ready);
    modport sink(input valid, input sample_in, output ready);
endinterface

/* rtl/iirb_out_if.sv */
interface iirb_out_if import iirb_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [SmpW-1:0] sample_out;

    modport source(output valid, output sample_out, input ready);
    modport sink(input valid, input sample_out, output ready);
endinterface

/* rtl/iirb_cfg_regs.sv */
module iirb_cfg_regs import iirb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    // unity forward gain, everything else zero
    localparam t_cfg CfgRst = '{
        bias: '0,
        feed: '0,
        fwd:  {{((MaxOrder-1)*CoefW){1'b0}}, FwdCoef0Rst}
    };

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_BIAS:  n_cfg.bias    = i_cfg_data[SmpW-1:0];
                REG_FEED1: n_cfg.feed[1] = i_cfg_data;
                REG_FEED2: n_cfg.feed[2] = i_cfg_data;
                REG_FEED3: n_cfg.feed[3] = i_cfg_data;
                REG_FWD0:  n_cfg.fwd[0]  = i_cfg_data;
                REG_FWD1:  n_cfg.fwd[1]  = i_cfg_data;
                REG_FWD2:  n_cfg.fwd[2]  = i_cfg_data;
                REG_FWD3:  n_cfg.fwd[3]  = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/iirb_mac.sv */
module iirb_mac import iirb_pkg::*; #(
    parameter int Order = DefOrder
) (
    input  t_cfg                   i_cfg,
    input  logic signed [SmpW-1:0] i_x0,
    input  t_hist                  i_xh,
    input  t_hist                  i_yh,
    output logic signed [SmpW-1:0] o_unbiased,
    output logic signed [SmpW-1:0] o_biased
);

    localparam logic signed [AccW-1:0] RndOff = AccW'(2**(FracW-1));

    logic signed [SmpW-1:0]  xv     [MaxOrder];
    logic signed [SmpW-1:0]  yv     [MaxOrder];
    logic signed [ProdW-1:0] p_fwd  [MaxOrder];
    logic signed [ProdW-1:0] p_feed [MaxOrder];
    logic signed [AccW-1:0]  acc;
    logic signed [AccW-1:0]  rnd;

    always_comb begin
        xv[0] = i_x0;
        yv[0] = '0;
        for (int i = 1; i < MaxOrder; i++) begin
            xv[i] = i_xh[i-1];
            yv[i] = i_yh[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < MaxOrder; i++) begin
            p_fwd[i] = $signed(i_cfg.fwd[i]) * xv[i];
            if (i > 0) begin
                p_feed[i] = $signed(i_cfg.feed[i]) * yv[i];
            end else begin
                p_feed[i] = '0;
            end
        end
    end

    // taps at ORDER and above drop out of the sum
    always_comb begin
        acc = '0;
        for (int i = 0; i < MaxOrder; i++) begin
            if (i < Order) begin
                acc = acc + AccW'(p_fwd[i]) + AccW'(p_feed[i]);
            end
        end
    end

    // round half up, then floor shift
    assign rnd        = (acc + RndOff) >>> FracW;
    assign o_unbiased = sat_smp(rnd);
    assign o_biased   = sat_smp(AccW'(o_unbiased) + AccW'(i_cfg.bias));

endmodule

/* rtl/iir_filter_with_output_bias_unit.sv */
// Channel  Dir  Payload              Transfer
// i_smp    in   sample_in  s16       valid & ready
// o_smp    out  sample_out s16       valid & ready
// i_cfg_*  in   idx 3b, data 18b     i_cfg_we
//
// One sample per cycle sustained while the receiver keeps ready high; output valid
// rises once the input register's sample moves into the free result register.
// The feedback loop runs from the history registers through the multiply-add,
// rounding and saturation combinationally back into the history.
// Reset (synchronous, active low) clears both histories and the valid flags, and
// loads the configuration registers with unity forward gain and all else zero.
// A stalled output holds the result; the input register still takes a sample while it is empty.
module iir_filter_with_output_bias_unit import iirb_pkg::*; #(
    parameter int Order = DefOrder
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    iirb_in_if.sink             i_smp,
    iirb_out_if.source          o_smp
);

    t_cfg                   w_cfg;
    logic                   r_in_vld;
    logic signed [SmpW-1:0] r_x0;
    t_hist                  r_xh;
    t_hist                  r_yh;
    logic                   r_out_vld;
    logic signed [SmpW-1:0] r_out;
    logic signed [SmpW-1:0] w_unbiased;
    logic signed [SmpW-1:0] w_biased;
    logic                   w_out_free;
    logic                   w_adv;
    logic                   w_in_xfer;

    iirb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    iirb_mac #(.Order(Order)) u_mac (
        .i_cfg      (w_cfg),
        .i_x0       (r_x0),
        .i_xh       (r_xh),
        .i_yh       (r_yh),
        .o_unbiased (w_unbiased),
        .o_biased   (w_biased)
    );

    assign w_out_free  = !r_out_vld || o_smp.ready;
    assign w_adv       = r_in_vld && w_out_free;
    assign i_smp.ready = !r_in_vld || w_adv;
    assign w_in_xfer   = i_smp.valid && i_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_xh      <= '0;
            r_yh      <= '0;
        end else begin
            if (w_in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_xh      <= {r_xh[HistDepth-2:0], r_x0};
                r_yh      <= {r_yh[HistDepth-2:0], w_unbiased};
            end else if (o_smp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_x0 <= i_smp.sample_in;
        end
        if (w_adv) begin
            r_out <= w_biased;
        end
    end

    assign o_smp.valid      = r_out_vld;
    assign o_smp.sample_out = r_out;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_out_free |-> !i_smp.ready)
        else $error("input taken while stage is blocked");

    a_xh_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_xh[0] == $past(r_x0))
        else $error("input history missed a sample");

    a_yh_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_yh[0] == $past(w_unbiased))
        else $error("feedback history missed a result");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_smp.valid) |-> $past(w_adv))
        else $error("output valid without a staged sample");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_smp.valid && !r_in_vld)
        else $error("pipeline not empty after reset");

endmodule

/* test/iir_filter_with_output_bias_unit_test.sv */
module iir_filter_with_output_bias_unit_test;
    import iirb_pkg::*;

    localparam int IdleLimit = 1000;

    // Tracks the filter state and the samples the block still owes us.
    class biased_iir_predictor;
        int bias;
        int feed[1:HistDepth];
        int fwd[MaxOrder];
        int x_hist[HistDepth];
        int y_hist[HistDepth];
        logic signed [SmpW-1:0] expected_samples[$];
        int n_checked;

        function new();
            bias = 0;
            foreach (feed[i]) feed[i] = 0;
            foreach (fwd[i]) fwd[i] = 0;
            fwd[0] = FwdCoef0Rst;
            foreach (x_hist[i]) begin
                x_hist[i] = 0;
                y_hist[i] = 0;
            end
            n_checked = 0;
        endfunction

        function void write_reg(t_reg_idx r, logic [CfgDataW-1:0] d);
            logic signed [SmpW-1:0]  b;
            logic signed [CoefW-1:0] c;
            b = d[SmpW-1:0];
            c = d[CoefW-1:0];
            case (r)
                REG_BIAS:  bias    = b;
                REG_FEED1: feed[1] = c;
                REG_FEED2: feed[2] = c;
                REG_FEED3: feed[3] = c;
                REG_FWD0:  fwd[0]  = c;
                REG_FWD1:  fwd[1]  = c;
                REG_FWD2:  fwd[2]  = c;
                REG_FWD3:  fwd[3]  = c;
                default: ;
            endcase
        endfunction

        function int clip16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        function void take_sample(logic signed [SmpW-1:0] s);
            longint acc;
            int     unb;
            int     x0;
            logic signed [SmpW-1:0] outv;
            x0  = s;
            acc = longint'(fwd[0]) * x0;
            for (int i = 1; i < MaxOrder; i++) begin
                if (i < DefOrder) begin
                    acc += longint'(fwd[i]) * x_hist[i-1];
                    acc += longint'(feed[i]) * y_hist[i-1];
                end
            end
            // round half up, then floor shift
            unb = clip16((acc + (longint'(1) <<< (FracW - 1))) >>> FracW);
            for (int i = HistDepth - 1; i > 0; i--) begin
                x_hist[i] = x_hist[i-1];
                y_hist[i] = y_hist[i-1];
            end
            x_hist[0] = x0;
            y_hist[0] = unb;
            outv = SmpW'(clip16(longint'(unb) + bias));
            expected_samples.push_back(outv);
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function bit check_sample(input logic signed [SmpW-1:0] got, output bit orphan,
                                  output logic signed [SmpW-1:0] want);
            orphan = 0;
            want   = '0;
            if (expected_samples.size() == 0) begin
                orphan = 1;
                return 0;
            end
            want = expected_samples.pop_front();
            n_checked++;
            return got === want;
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    iirb_in_if  smp_in();
    iirb_out_if smp_out();

    iir_filter_with_output_bias_unit #(.Order(DefOrder)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_smp     (smp_in),
        .o_smp     (smp_out)
    );

    biased_iir_predictor filt = new();
    int          n_errors = 0;
    int          idle_cycles = 0;
    logic [15:0] ready_pat;
    logic [3:0]  ready_pos = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("MISMATCH: %s", what);
        n_errors++;
    endtask

    // receiver stalls on a repeating pattern, one bit of the 16-bit ready_pat at a time
    always @(negedge i_clk) begin
        smp_out.ready <= ready_pat[ready_pos];
        ready_pos     <= ready_pos + 1'b1;
    end

    always @(posedge i_clk) begin : monitor
        logic signed [SmpW-1:0] want;
        bit orphan;
        bit in_xfer;
        bit out_xfer;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            in_xfer  = smp_in.valid && smp_in.ready;
            out_xfer = smp_out.valid && smp_out.ready;
            if (in_xfer) begin
                filt.take_sample(smp_in.sample_in);
            end
            if (out_xfer) begin
                if (!filt.check_sample(smp_out.sample_out, orphan, want)) begin
                    if (orphan) begin
                        report_mismatch($sformatf("unexpected output %0d",
                                                  smp_out.sample_out));
                    end else begin
                        report_mismatch($sformatf("output %0d: got %0d expected %0d",
                                                  filt.n_checked - 1,
                                                  smp_out.sample_out, want));
                    end
                end
            end
            if (in_xfer || out_xfer) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IdleLimit) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(logic signed [SmpW-1:0] s);
        smp_in.valid     <= 1'b1;
        smp_in.sample_in <= s;
        do @(posedge i_clk); while (!smp_in.ready);
        @(negedge i_clk);
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            smp_in.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        smp_in.valid <= 1'b0;
        while (filt.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(logic [CfgDataW-1:0] vals[MaxOrder*2]);
        t_reg_idx r;
        r = r.first();
        repeat (r.num()) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r;
            i_cfg_data <= vals[int'(r)];
            filt.write_reg(r, vals[int'(r)]);
            @(negedge i_clk);
            r = r.next();
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [SmpW-1:0] rand_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        if (kind <= 3) return SmpW'(int'($urandom_range(0, 512)) - 256);
        return SmpW'($urandom());
    endfunction

    function automatic logic [CfgDataW-1:0] rand_coef(bit tame, int span);
        if (!tame) return CfgDataW'($urandom());
        return CfgDataW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic run_random(int n_items, bit gappy, int drain_at);
        int burst;
        burst = $urandom_range(1, 32);
        for (int k = 0; k < n_items; k++) begin
            if (k == drain_at) drain();
            send_sample(rand_sample());
            if (gappy) begin
                burst = burst - 1;
                if (burst == 0) begin
                    hold_off($urandom_range(0, 8));
                    burst = $urandom_range(1, 32);
                end
            end
        end
    endtask

    initial begin
        logic [CfgDataW-1:0] cfg[MaxOrder*2];
        bit tame;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_BIAS;
        i_cfg_data       = '0;
        smp_in.valid     = 1'b0;
        smp_in.sample_in = '0;
        smp_out.ready    = 1'b0;
        ready_pat        = 16'hFFFF;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: unity gain, no bias
        send_sample(16'sh0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'sh0000);
        ready_pat = 16'hB6DB;
        run_random(65, 1'b1, -1);
        drain();

        // half gain: odd inputs land on rounding ties
        cfg = '{default: '0};
        cfg[REG_FWD0] = 18'h08000;
        configure(cfg);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        drain();

        // all weights at max, bias at max: both saturation stages
        cfg = '{default: 18'h1FFFF};
        cfg[REG_BIAS] = 18'h07FFF;
        configure(cfg);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        drain();

        // all weights at min; bias upper bits set but ignored
        cfg = '{default: 18'h20000};
        cfg[REG_BIAS] = 18'h38000;
        configure(cfg);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            tame = (ph % 4) != 3;
            cfg[REG_BIAS]  = $urandom_range(0, 3) == 0 ? CfgDataW'($urandom()) :
                             CfgDataW'(int'($urandom_range(0, 2000)) - 1000);
            cfg[REG_FEED1] = rand_coef(tame, 16384);
            cfg[REG_FEED2] = rand_coef(tame, 16384);
            cfg[REG_FEED3] = rand_coef(tame, 16384);
            cfg[REG_FWD0]  = rand_coef(tame, 65536);
            cfg[REG_FWD1]  = rand_coef(tame, 32768);
            cfg[REG_FWD2]  = rand_coef(tame, 32768);
            cfg[REG_FWD3]  = rand_coef(tame, 32768);
            configure(cfg);
            if (ph % 3 == 0) begin
                ready_pat = 16'hFFFF;
            end else begin
                ready_pat = 16'($urandom() & $urandom()) | 16'h0001;
            end
            // mid-stream pause until the output side is empty
            run_random(70, ph % 2 == 1, ph == 2 ? 35 : -1);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (filt.pending() != 0) begin
            report_mismatch($sformatf("%0d expected samples never arrived", filt.pending()));
        end
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/iirb_pkg.sv
rtl/iirb_in_if.sv
rtl/iirb_out_if.sv
rtl/iirb_cfg_regs.sv
rtl/iirb_mac.sv
rtl/iir_filter_with_output_bias_unit.sv
test/iir_filter_with_output_bias_unit_test.sv
